>>> rtl/core/ebcpu_pkg.sv
`timescale 1ns / 1ps
package ebcpu_pkg;

  localparam logic [15:0] VEC_RESET_LO = 16'hFFFC;
  localparam logic [15:0] VEC_RESET_HI = 16'hFFFD;
  localparam logic [15:0] VEC_IRQ_LO   = 16'hFFFE;
  localparam logic [15:0] VEC_IRQ_HI   = 16'hFFFF;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;
  localparam logic [7:0]  PUSH_BITS    = 8'h30;
  localparam logic [7:0]  A_RESET      = 8'hAA;
  localparam logic [7:0]  P_RESET      = 8'h02;

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_D = 8'h08;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;

  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_ORA_IZX = 8'h01;
  localparam logic [7:0] OP_SLO_IZX = 8'h03;
  localparam logic [7:0] OP_NOP_ZP  = 8'h04;
  localparam logic [7:0] OP_ORA_ZP  = 8'h05;
  localparam logic [7:0] OP_ASL_ZP  = 8'h06;
  localparam logic [7:0] OP_SLO_ZP  = 8'h07;
  localparam logic [7:0] OP_PHP     = 8'h08;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_CLD     = 8'hD8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ready_req;
    logic       set_overflow;
  } cyc_in_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        write_enable;
    logic        opcode_fetch;
    logic        jammed;
  } cyc_out_t;

  // last step index of an opcode, zero for anything that jams
  function automatic logic [3:0] last_step(input logic [7:0] op);
    logic [3:0] r;
    unique case (op)
      OP_BRK:                         r = 4'd6;
      OP_ORA_IZX:                     r = 4'd5;
      OP_SLO_IZX:                     r = 4'd7;
      OP_NOP_ZP, OP_ORA_ZP, OP_PHP:   r = 4'd2;
      OP_ASL_ZP, OP_SLO_ZP:           r = 4'd4;
      OP_SEI, OP_TXS, OP_LDX_IMM, OP_CLD: r = 4'd1;
      default:                        r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p & ~(FLAG_N | FLAG_Z);
    if (v[7]) r = r | FLAG_N;
    if (v == 8'h00) r = r | FLAG_Z;
    return r;
  endfunction

endpackage

>>> rtl/core/ebcpu_in_if.sv
`timescale 1ns / 1ps
interface ebcpu_in_if import ebcpu_pkg::*; ();
  logic    valid;
  logic    ready;
  cyc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ebcpu_out_if.sv
`timescale 1ns / 1ps
interface ebcpu_out_if import ebcpu_pkg::*; ();
  logic     valid;
  logic     ready;
  cyc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/eight_bit_cpu_cycle_core.sv
`timescale 1ns / 1ps
// channel  | dir | payload
// cyc_in   | in  | read_data, ready_req, set_overflow
// cyc_out  | out | bus_address, write_data, write_enable, opcode_fetch, jammed
//
// one bus cycle per transaction: each input transaction yields one result
// transaction in the next clock, from one pass of logic into the result register
// a new input is taken every clock while the result register is empty or drained
// rst loads the registers with their reset values; the reset sequence then reads at
// pc, from the stack page and from the reset vector before the first opcode fetch
// cyc_out.ready low holds the result and stops input; ready_req low repeats a read
module eight_bit_cpu_cycle_core import ebcpu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ebcpu_in_if.sink      cyc_in,
  ebcpu_out_if.source   cyc_out
);

  logic [7:0]  a, a_next, x, x_next, s, s_next, p, p_next;
  logic [15:0] pc, pc_next, ea, ea_next;
  logic [7:0]  op, op_next, zp, zp_next, ob, ob_next;
  logic [3:0]  step, step_next;
  logic        rst_seq, rst_seq_next, exec, exec_next, halted, halted_next;
  cyc_out_t    res, res_next;
  logic        out_valid;
  logic        accept;

  logic [7:0]  d;
  logic [3:0]  t;
  logic [3:0]  last;
  logic        done;
  logic [7:0]  v;

  assign cyc_in.ready  = !out_valid || cyc_out.ready;
  assign accept        = cyc_in.valid && cyc_in.ready;
  assign cyc_out.valid = out_valid;
  assign cyc_out.data  = res;
  assign d             = cyc_in.data.read_data;

  always_comb begin
    a_next = a; x_next = x; s_next = s; p_next = p; pc_next = pc; ea_next = ea;
    op_next = op; zp_next = zp; ob_next = ob; step_next = step;
    rst_seq_next = rst_seq; exec_next = exec; halted_next = halted;
    res_next = res;
    t = 4'd0; last = 4'd0; done = 1'b0; v = 8'h00;
    if (cyc_in.data.set_overflow) p_next = p_next | FLAG_V;
    res_next.write_data = 8'h00; res_next.write_enable = 1'b0;
    res_next.opcode_fetch = 1'b0;
    if (!res.write_enable && !cyc_in.data.ready_req) begin
      res_next = res;
    end else if (rst_seq) begin
      if (step == 4'd7) pc_next[7:0] = d;
      if (step >= 4'd8) begin
        pc_next[15:8] = d;
        rst_seq_next = 1'b0;
        done = 1'b1;
      end else begin
        if (step < 4'd3) res_next.bus_address = pc;
        else if (step < 4'd6) begin
          res_next.bus_address = {STACK_PAGE, s};
          s_next = s - 8'd1;
        end else if (step == 4'd6) res_next.bus_address = VEC_RESET_LO;
        else res_next.bus_address = VEC_RESET_HI;
        step_next = step + 4'd1;
      end
    end else if (halted) begin
      res_next.bus_address = pc;
    end else if (!exec && last_step(d) == 4'd0) begin
      op_next = d;
      halted_next = 1'b1;
      res_next.bus_address = pc;
    end else begin
      if (!exec) begin
        op_next = d;
      end else begin
        t = step;
        // a read cycle finished: absorb its data
        if (!res.write_enable) begin
          if (t == 4'd1) begin
            priority case (op)
              OP_SEI:     p_next = p_next | FLAG_I;
              OP_CLD:     p_next = p_next & ~FLAG_D;
              OP_TXS:     s_next = x;
              OP_LDX_IMM: begin x_next = d; p_next = with_nz(p_next, d); end
              OP_ORA_IZX, OP_SLO_IZX, OP_NOP_ZP, OP_ORA_ZP, OP_ASL_ZP,
              OP_SLO_ZP:  zp_next = d;
              default: ;
            endcase
          end else begin
            priority case (op)
              OP_BRK: begin
                if (t == 4'd5) pc_next[7:0] = d;
                else if (t == 4'd6) pc_next[15:8] = d;
              end
              OP_ORA_ZP: if (t == 4'd2) begin
                a_next = a | d; p_next = with_nz(p_next, a | d);
              end
              OP_ASL_ZP, OP_SLO_ZP: if (t == 4'd2) ob_next = d;
              OP_ORA_IZX, OP_SLO_IZX: begin
                if (t == 4'd2) zp_next = zp + x;
                else if (t == 4'd3) ea_next[7:0] = d;
                else if (t == 4'd4) ea_next[15:8] = d;
                else if (t == 4'd5) begin
                  if (op == OP_ORA_IZX) begin
                    a_next = a | d; p_next = with_nz(p_next, a | d);
                  end else ob_next = d;
                end
              end
              default: ;
            endcase
          end
        end
      end
      last = last_step(op_next);
      if (t >= last) begin
        done = 1'b1;
      end else begin
        step_next = t + 4'd1;
        exec_next = 1'b1;
        if (step_next == 4'd1) begin
          res_next.bus_address = pc_next;
          if (op_next != OP_PHP && op_next != OP_SEI && op_next != OP_TXS &&
              op_next != OP_CLD)
            pc_next = pc_next + 16'd1;
        end else begin
          priority case (op_next)
            OP_BRK: begin
              if (step_next <= 4'd4) begin
                res_next.bus_address = {STACK_PAGE, s_next};
                res_next.write_enable = 1'b1;
                if (step_next == 4'd2) res_next.write_data = pc_next[15:8];
                else if (step_next == 4'd3) res_next.write_data = pc_next[7:0];
                else begin
                  res_next.write_data = p_next | PUSH_BITS;
                  p_next = p_next | FLAG_I;
                end
                s_next = s_next - 8'd1;
              end else if (step_next == 4'd5) res_next.bus_address = VEC_IRQ_LO;
              else res_next.bus_address = VEC_IRQ_HI;
            end
            OP_PHP: begin
              res_next.bus_address = {STACK_PAGE, s_next};
              res_next.write_enable = 1'b1;
              res_next.write_data = p_next | PUSH_BITS;
              s_next = s_next - 8'd1;
            end
            OP_NOP_ZP, OP_ORA_ZP, OP_ASL_ZP, OP_SLO_ZP: begin
              res_next.bus_address = {8'h00, zp_next};
              if (step_next >= 4'd3) begin
                res_next.write_enable = 1'b1;
                res_next.write_data = ob_next;
              end
            end
            OP_ORA_IZX, OP_SLO_IZX: begin
              if (step_next <= 4'd3) res_next.bus_address = {8'h00, zp_next};
              else if (step_next == 4'd4) res_next.bus_address = {8'h00, zp_next + 8'd1};
              else res_next.bus_address = ea_next;
              if (step_next >= 4'd6) begin
                res_next.write_enable = 1'b1;
                res_next.write_data = ob_next;
              end
            end
            default: res_next.bus_address = pc_next;
          endcase
          // dummy write of the old byte, then shift it
          if (step_next == 4'd3 && (op_next == OP_ASL_ZP || op_next == OP_SLO_ZP) ||
              step_next == 4'd6 && op_next == OP_SLO_IZX) begin
            v = ob_next << 1;
            p_next = ob_next[7] ? (p_next | FLAG_C) : (p_next & ~FLAG_C);
            ob_next = v;
            if (op_next == OP_ASL_ZP) p_next = with_nz(p_next, v);
            else begin
              a_next = a_next | v; p_next = with_nz(p_next, a_next | v);
            end
          end
        end
      end
    end
    if (done) begin
      res_next.bus_address = pc_next;
      res_next.opcode_fetch = 1'b1;
      pc_next = pc_next + 16'd1;
      step_next = 4'd0;
      exec_next = 1'b0;
    end
    if (!(!res.write_enable && !cyc_in.data.ready_req)) res_next.jammed = halted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= A_RESET; x <= 8'h00; s <= 8'h00; p <= P_RESET; pc <= 16'h0000;
      op <= 8'h00; step <= 4'd0; rst_seq <= 1'b1; exec <= 1'b0;
      zp <= 8'h00; ea <= 16'h0000; ob <= 8'h00; halted <= 1'b0;
      res <= '0; out_valid <= 1'b0;
    end else begin
      if (accept) begin
        a <= a_next; x <= x_next; s <= s_next; p <= p_next; pc <= pc_next;
        op <= op_next; step <= step_next; rst_seq <= rst_seq_next;
        exec <= exec_next; zp <= zp_next; ea <= ea_next; ob <= ob_next;
        halted <= halted_next; res <= res_next;
        out_valid <= 1'b1;
      end else if (cyc_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_jam_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> res.jammed) else $error("halted core not flagged");
  a_fetch_read: assert property (@(posedge clk) disable iff (rst)
    res.opcode_fetch |-> !res.write_enable) else $error("opcode fetch on write");
  a_no_jam_in_reset: assert property (@(posedge clk) disable iff (rst)
    rst_seq |-> !halted) else $error("jam during reset sequence");
  a_write_moves: assert property (@(posedge clk) disable iff (rst)
    accept && res.write_enable && !rst_seq |=> $past(step) != step || !exec)
    else $error("write cycle stalled");
`endif

endmodule
